>>> hdl/assert_macros.svh
// Assertion helpers included by tree_plru_replacement_top. Both macros sample on clk and are
// disabled while rst_n is low, so the enclosing module must have both.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every rising edge out of reset.
`define TPLRU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition or sequence never matches at a rising edge out of reset.
`define TPLRU_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) not (expr)) else $error(msg);

`else

`define TPLRU_ASSERT(name, prop, msg)

`define TPLRU_ASSERT_NEVER(name, expr, msg)

`endif

`endif

>>> hdl/tplru_pkg.sv
package tplru_pkg;

    localparam int CFG_W = 5;   // ways_in_use register
    localparam int SET_W = 8;   // set_index field
    localparam int WAY_W = 4;   // way_index and victim_way fields
    localparam int LVL_W = 3;   // tree depth, up to 5 levels for 32 ways

    localparam logic [CFG_W-1:0] WAYS_RESET = 5'd16;

    // Request kinds carried in req_type
    localparam logic REQ_TOUCH  = 1'b0;
    localparam logic REQ_VICTIM = 1'b1;

    // Walk setup derived from the way count register
    typedef struct packed {
        logic [LVL_W-1:0] levels;    // tree depth for the rounded-up way count
        logic [CFG_W-1:0] last_way;  // highest way that may be chosen
    } walk_ctrl_t;

endpackage

>>> hdl/tplru_walk.sv
module tplru_walk #(
    parameter int MAX_WAYS = 16
) (
    input  tplru_pkg::walk_ctrl_t                      ctrl,
    input  logic [(1 << $clog2(MAX_WAYS)) - 2:0]       tree_in,
    input  logic [tplru_pkg::WAY_W-1:0]                way_index,
    output logic [(1 << $clog2(MAX_WAYS)) - 2:0]       tree_out,
    output logic [tplru_pkg::WAY_W-1:0]                victim_way
);
    import tplru_pkg::*;

    localparam int LMAX = $clog2(MAX_WAYS);

    logic [LMAX-1:0]  way_ext;
    logic [LMAX-1:0]  prefix;
    logic [LMAX-1:0]  node;
    logic [LMAX-1:0]  shifted;
    logic [LVL_W-1:0] sh;

    logic [LMAX-1:0]  vnode;
    logic [LMAX-1:0]  vway;
    logic             vbit;
    logic [CFG_W-1:0] vway_w;

    // Touch: each level's node and direction follow directly from the way bits
    always_comb
    begin
        tree_out = tree_in;
        way_ext  = LMAX'(way_index);
        prefix   = '0;
        node     = '0;
        shifted  = '0;
        sh       = '0;
        for (int d = 0; d < LMAX; d++)
        begin
            if (LVL_W'(d) < ctrl.levels)
            begin
                sh       = ctrl.levels - LVL_W'(d);
                prefix   = (way_ext >> sh) & LMAX'((1 << d) - 1);
                node     = LMAX'((1 << d) - 1) + prefix;
                shifted  = way_ext >> (sh - LVL_W'(1));
                tree_out[node] = shifted[0];
            end
        end
    end

    // Victim: walk against the stored directions, then clamp to the way count
    always_comb
    begin
        vnode = '0;
        vway  = '0;
        vbit  = 1'b0;
        for (int d = 0; d < LMAX; d++)
        begin
            if (LVL_W'(d) < ctrl.levels)
            begin
                vbit  = tree_in[vnode];
                vway  = LMAX'({vway, ~vbit});
                vnode = LMAX'({vnode, 1'b0}) + (vbit ? LMAX'(1) : LMAX'(2));
            end
        end
        vway_w     = CFG_W'(vway);
        victim_way = WAY_W'((vway_w > ctrl.last_way) ? ctrl.last_way : vway_w);
    end

endmodule

>>> hdl/tree_plru_replacement_top.sv
// Tree pseudo-LRU replacement state for a set-associative cache. Each set
// holds one bit per tree node in an internal memory that reads as all zero
// after reset (per-set valid flops, no clearing pass, so requests are taken
// right out of reset). A touch (tuser = 0) records the path to way_index; a
// victim request (tuser = 1) walks the opposite path and returns one result
// transfer with the chosen way, clamped to ways_in_use - 1. The block takes
// one request per cycle, touches and victims mixed in any order, including
// back-to-back requests to the same set. A victim result reaches the
// master side from its request transfer through the registered tree memory
// read, then the walk between that read register and the output
// register. The slave side only stalls while a finished result waits on the
// master side and a further victim request is in the walk stage. ways_in_use
// (2 to MAX_WAYS, reset 16) may only be written while no request is in flight;
// writing it does not clear the trees. Sets at or beyond NUM_SETS are ignored
// by touches and read as empty by victim requests.
module tree_plru_replacement_top #(
    parameter int NUM_SETS = 256,
    parameter int MAX_WAYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] set_index, [11:8] way_index, [15:12] zero
    input  logic [0:0]  s_axis_tuser,   // [0] req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] victim_way, [7:4] zero

    input  logic                          cfg_wr_en,
    input  logic [tplru_pkg::CFG_W-1:0]   cfg_wr_data
);
    import tplru_pkg::*;

`include "assert_macros.svh"

    localparam int LMAX   = $clog2(MAX_WAYS);
    localparam int TREE_W = (1 << LMAX) - 1;
    localparam int DEPTH  = (NUM_SETS < 256) ? NUM_SETS : 256;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration
    logic [CFG_W-1:0] ways_in_use_reg;
    logic [CFG_W:0]   ways_clamped;
    walk_ctrl_t       ctrl;

    // Tree store: memory plus one valid flop per set
    logic [TREE_W-1:0] tree_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;

    // Input side
    logic [SET_W-1:0] in_set;
    logic [WAY_W-1:0] in_way;
    logic             in_range;
    logic [AW-1:0]    in_addr;
    logic             accept;

    // Walk stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_req_reg;
    logic [SET_W-1:0]  s1_set_reg;
    logic [WAY_W-1:0]  s1_way_reg;
    logic              s1_inr_reg;
    logic [TREE_W-1:0] rd_tree_reg;
    logic              rd_valid_reg;
    logic              stall;
    logic              s1_adv;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              fwd_hit;
    logic [TREE_W-1:0] tree_cur;
    logic [TREE_W-1:0] tree_new;
    logic [WAY_W-1:0]  victim;

    // Last tree written, for a read taken at the same edge as that write
    logic              wr_valid_reg;
    logic [SET_W-1:0]  wr_set_reg;
    logic [TREE_W-1:0] wr_tree_reg;

    // Output register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WAY_W-1:0] out_way_reg;

    // Round the way count: clamp to the legal range, depth from the last way
    always_comb
    begin
        if ({1'b0, ways_in_use_reg} < (CFG_W+1)'(2))
        begin
            ways_clamped = (CFG_W+1)'(2);
        end
        else if (32'(ways_in_use_reg) > MAX_WAYS)
        begin
            ways_clamped = (CFG_W+1)'(MAX_WAYS);
        end
        else
        begin
            ways_clamped = {1'b0, ways_in_use_reg};
        end
        ctrl.last_way = CFG_W'(ways_clamped - (CFG_W+1)'(1));
        ctrl.levels   = '0;
        for (int k = 0; k < CFG_W; k++)
        begin
            if ((ctrl.last_way >> k) != '0)
            begin
                ctrl.levels = LVL_W'(k + 1);
            end
        end
    end

    assign in_set   = s_axis_tdata[7:0];
    assign in_way   = s_axis_tdata[11:8];
    assign in_range = 32'(in_set) < NUM_SETS;
    assign in_addr  = AW'(in_set);

    // Hold the walk stage only when a victim result has nowhere to go
    assign stall  = s1_valid_reg && (s1_req_reg == REQ_VICTIM)
                    && out_valid_reg && !m_axis_tready;
    assign s1_adv = s1_valid_reg && !stall;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !stall;

    assign wr_en   = s1_adv && (s1_req_reg == REQ_TOUCH) && s1_inr_reg;
    assign wr_addr = AW'(s1_set_reg);

    // Pick the newest tree: forwarded write, stored entry, or empty
    assign fwd_hit = wr_valid_reg && (wr_set_reg == s1_set_reg);

    always_comb
    begin
        if (!s1_inr_reg)
        begin
            tree_cur = '0;
        end
        else if (fwd_hit)
        begin
            tree_cur = wr_tree_reg;
        end
        else if (rd_valid_reg)
        begin
            tree_cur = rd_tree_reg;
        end
        else
        begin
            tree_cur = '0;
        end
    end

    tplru_walk #(
        .MAX_WAYS (MAX_WAYS)
    ) u_walk (
        .ctrl       (ctrl),
        .tree_in    (tree_cur),
        .way_index  (s1_way_reg),
        .tree_out   (tree_new),
        .victim_way (victim)
    );

    // Advance the walk stage on every accepted transfer, drop it once it moves on, hold it while stalled
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Load a victim result, or drop the one just taken
    always_comb
    begin
        if (s1_adv && (s1_req_reg == REQ_VICTIM))
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_in_use_reg <= WAYS_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            wr_valid_reg    <= 1'b0;
            valid_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ways_in_use_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                wr_valid_reg       <= 1'b1;
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload: request fields, memory read, last write and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= s_axis_tuser[0];
            s1_set_reg   <= in_set;
            s1_way_reg   <= in_way;
            s1_inr_reg   <= in_range;
            rd_tree_reg  <= tree_mem[in_addr];
            rd_valid_reg <= in_range && valid_reg[in_addr];
        end
        if (wr_en)
        begin
            tree_mem[wr_addr] <= tree_new;
            wr_set_reg        <= s1_set_reg;
            wr_tree_reg       <= tree_new;
        end
        if (s1_adv && (s1_req_reg == REQ_VICTIM))
        begin
            out_way_reg <= victim;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_way_reg};

    // A victim leaving the walk stage must show up on the master side
    `TPLRU_ASSERT(a_victim_to_out, s1_adv && (s1_req_reg == REQ_VICTIM) |=> m_axis_tvalid, "victim request lost its result")

    // The slave side only stalls behind a waiting result
    `TPLRU_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without a waiting result")

    // A touch write must be visible to the next request to the same set
    `TPLRU_ASSERT(a_fwd_track, wr_en |=> wr_valid_reg && (wr_set_reg == $past(s1_set_reg)), "write forwarding register out of step")

    // Touches never create a result
    `TPLRU_ASSERT_NEVER(a_touch_no_out, !out_valid_reg && s1_valid_reg && (s1_req_reg == REQ_TOUCH) ##1 m_axis_tvalid, "touch produced a result")

endmodule

>>> bench/tb_tree_plru_replacement_top.sv
`timescale 1ns / 1ps

module tb_tree_plru_replacement_top;

    import tplru_pkg::*;

    localparam int NUM_SETS    = 256;
    localparam int MAX_WAYS    = 16;
    localparam int PHASE_COUNT = 14;
    localparam int PHASE_ITEMS = 88;   // request transfers per random phase
    localparam int SETTLE_CYC  = 4;    // block latency plus margin
    localparam int MAX_PRINTS  = 50;

    // One request as the sender queues it
    typedef struct packed {
        logic             kind;      // REQ_TOUCH or REQ_VICTIM
        logic [SET_W-1:0] set_idx;
        logic [WAY_W-1:0] way_idx;
    } plru_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] set_index, [11:8] way_index, [15:12] zero
    logic [0:0]  s_axis_tuser = '0;   // [0] req_type

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [3:0] victim_way, [7:4] zero

    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = WAYS_RESET;

    // Shadow copy of the replacement trees and the way count register
    logic [14:0]      plru_bits [0:NUM_SETS-1];
    logic [CFG_W-1:0] ways_cfg;

    plru_req_t         pending_reqs [$];   // requests waiting for the driver
    logic [WAY_W-1:0]  victim_due [$];     // predicted victim ways, oldest first

    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned mismatch_count = 0;

    // Idle controls, percent chance of starting a burst per sent transfer or per ready cycle
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned send_gap      = 0;
    int unsigned recv_hold     = 0;

    plru_req_t        next_req;
    logic [WAY_W-1:0] want_way;

    tree_plru_replacement_top #(
        .NUM_SETS (NUM_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Way count as the block uses it: out-of-range settings clamp to 2 or MAX_WAYS
    function automatic int unsigned ways_bounded(logic [CFG_W-1:0] cfg);
        int unsigned w = 32'(cfg);
        if (w < 2)
            w = 2;
        if (w > MAX_WAYS)
            w = MAX_WAYS;
        return w;
    endfunction

    // Levels of the tree: log2 of the way count rounded up to a power of two
    function automatic int unsigned tree_depth(logic [CFG_W-1:0] cfg);
        int unsigned w = ways_bounded(cfg);
        int unsigned d = 0;
        while ((1 << d) < w)
            d++;
        return d;
    endfunction

    // Record the path to a way, most significant way bit at the root.
    // Only the low depth bits of the way steer the walk.
    function automatic void apply_touch(logic [SET_W-1:0] set_idx, logic [WAY_W-1:0] way_idx);
        int unsigned node = 0;
        int unsigned d = tree_depth(ways_cfg);
        logic b;
        for (int i = d; i > 0; i--)
        begin
            b = way_idx[i-1];
            plru_bits[set_idx][node] = b;
            node = b ? 2 * node + 2 : 2 * node + 1;
        end
    endfunction

    // Walk against the recorded directions; clamp past the configured count
    function automatic logic [WAY_W-1:0] predict_victim(logic [SET_W-1:0] set_idx);
        int unsigned d = tree_depth(ways_cfg);
        int unsigned span = 1 << d;
        int unsigned node = 0;
        int unsigned way = 0;
        logic b;
        for (int i = 0; i < d; i++)
        begin
            b = plru_bits[set_idx][node];
            if (!b)
                way += span >> (i + 1);
            node = b ? 2 * node + 1 : 2 * node + 2;
        end
        if (way > ways_bounded(ways_cfg) - 1)
            way = ways_bounded(ways_cfg) - 1;
        return way[WAY_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic queue_req(logic kind, logic [SET_W-1:0] set_idx, logic [WAY_W-1:0] way_idx);
        plru_req_t r;
        r.kind = kind;
        r.set_idx = set_idx;
        r.way_idx = way_idx;
        pending_reqs.push_back(r);
        queued_total++;
    endtask

    // Hold the sender until every queued transfer is taken and every victim
    // result is back, then let the block settle. Flag results that never come.
    task automatic settle_block();
        int unsigned waited = 0;
        while (accepted_total != queued_total)
            @(posedge clk);
        while (victim_due.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (victim_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d victim results never arrived", victim_due.size()));
            victim_due.delete();
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write the way count register; only called with the block idle
    task automatic write_ways(logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ways_cfg = value;
    endtask

    // Way count for each random phase: clamped low and high settings,
    // non-powers of two, and a return to the reset value at the end
    function automatic logic [CFG_W-1:0] plan_ways(int p);
        case (p)
            0:       return 5'd2;
            1:       return 5'd31;
            2:       return 5'd0;
            3:       return 5'd1;
            4:       return 5'd3;
            5:       return 5'd5;
            6:       return 5'd7;
            7:       return 5'd9;
            8:       return 5'd12;
            9:       return 5'd17;
            10:      return 5'd4;
            11:      return 5'd8;
            12:      return 5'd15;
            default: return 5'd16;
        endcase
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 8;
            2:       return 25;
            default: return 50;
        endcase
    endfunction

    // Driver: predict each request at its transfer, then present the next
    // one or idle for a burst of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == REQ_TOUCH)
                    apply_touch(s_axis_tdata[7:0], s_axis_tdata[11:8]);
                else
                    victim_due.push_back(predict_victim(s_axis_tdata[7:0]));
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, next_req.way_idx, next_req.set_idx};
                    s_axis_tuser  <= next_req.kind;
                    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
                        send_gap = $urandom_range(1, 18);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction,
    // and stall the master side in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (victim_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected victim_way %0d", m_axis_tdata[3:0]));
                end
                else
                begin
                    want_way = victim_due.pop_front();
                    if (m_axis_tdata[3:0] !== want_way)
                        report_mismatch($sformatf("victim_way %0d, predicted %0d",
                                                  m_axis_tdata[3:0], want_way));
                end
            end
            if (recv_hold != 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct)
                    recv_hold = $urandom_range(1, 18);
            end
        end
    end

    // Stimulus: directed requests at the reset way count, then one random
    // phase per way count setting, draining the block before each write.
    initial
    begin
        int unsigned phase_items;
        int unsigned burst;
        logic [SET_W-1:0] focus [0:5];
        logic [SET_W-1:0] s;

        for (int i = 0; i < NUM_SETS; i++)
            plru_bits[i] = '0;
        ways_cfg = WAYS_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 25;

        // Fresh trees read as all zero: expect the last way
        queue_req(REQ_VICTIM, 8'h00, 4'h0);
        queue_req(REQ_VICTIM, 8'hFF, 4'hF);   // way field ignored on a victim request
        // Touch the top way, then the bottom way, checking the flip each time
        queue_req(REQ_TOUCH,  8'h00, 4'hF);
        queue_req(REQ_VICTIM, 8'h00, 4'h0);
        queue_req(REQ_TOUCH,  8'h00, 4'h0);
        queue_req(REQ_VICTIM, 8'h00, 4'h5);
        // Touch and victim requests queued back to back on the same set
        queue_req(REQ_TOUCH,  8'hFF, 4'hA);
        queue_req(REQ_VICTIM, 8'hFF, 4'h0);
        queue_req(REQ_TOUCH,  8'hAA, 4'h5);
        queue_req(REQ_TOUCH,  8'hAA, 4'h5);
        queue_req(REQ_VICTIM, 8'hAA, 4'hA);
        queue_req(REQ_TOUCH,  8'h55, 4'h9);
        queue_req(REQ_VICTIM, 8'h55, 4'h6);
        queue_req(REQ_TOUCH,  8'h00, 4'h8);
        queue_req(REQ_TOUCH,  8'h00, 4'h7);
        queue_req(REQ_VICTIM, 8'h00, 4'h0);
        queue_req(REQ_VICTIM, 8'h00, 4'h0);
        queue_req(REQ_TOUCH,  8'hFF, 4'hF);
        queue_req(REQ_TOUCH,  8'hFF, 4'hE);
        queue_req(REQ_TOUCH,  8'hFF, 4'hD);
        queue_req(REQ_VICTIM, 8'hFF, 4'h0);
        queue_req(REQ_TOUCH,  8'h01, 4'h3);
        queue_req(REQ_VICTIM, 8'h80, 4'hC);
        // Drain fully before the first register write
        settle_block();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_ways(plan_ways(p));
            // Drop idling altogether in the last phase
            if (p == PHASE_COUNT - 1)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = pick_idle_pct();
                recv_idle_pct = pick_idle_pct();
            end
            // Concentrate most traffic on a few sets so their trees get deep history
            for (int f = 0; f < 6; f++)
                focus[f] = SET_W'($urandom_range(NUM_SETS - 1));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 65)
                begin
                    // Touch a few ways of one set, then ask it for a victim
                    s = focus[$urandom_range(5)];
                    burst = $urandom_range(1, 4);
                    repeat (burst) queue_req(REQ_TOUCH, s, WAY_W'($urandom_range(15)));
                    queue_req(REQ_VICTIM, s, WAY_W'($urandom_range(15)));
                    phase_items += burst + 1;
                end
                else
                begin
                    queue_req(1'($urandom_range(1)), SET_W'($urandom_range(NUM_SETS - 1)),
                              WAY_W'($urandom_range(15)));
                    phase_items++;
                end
            end
            settle_block();
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
